>>> sv/frame_builder_rotating_checksum_top_defines.svh
// Assertion macros shared by the frame builder RTL.
`ifndef FRAME_BUILDER_ROTATING_CHECKSUM_TOP_DEFINES_SVH
`define FRAME_BUILDER_ROTATING_CHECKSUM_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FBRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FBRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/fbrc_pkg.sv
// Types, codes and helper functions of the frame builder.
package fbrc_pkg;

  localparam int NUM_PRE_REGS = 4;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [7:0] BYTE_MASK = 8'hFF;

  // Input mode codes
  localparam logic MODE_HEADER  = 1'b0;
  localparam logic MODE_PAYLOAD = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_PRE_COUNT = 3'd0;
  localparam logic [2:0] CFG_PRE_BYTE0 = 3'd1;
  localparam logic [2:0] CFG_PRE_BYTE1 = 3'd2;
  localparam logic [2:0] CFG_PRE_BYTE2 = 3'd3;
  localparam logic [2:0] CFG_PRE_BYTE3 = 3'd4;

  localparam logic [2:0] PRE_COUNT_RESET = 3'd2;

  typedef enum logic [1:0] {
    KIND_PREAMBLE = 2'd0,
    KIND_LENGTH   = 2'd1,
    KIND_PAYLOAD  = 2'd2,
    KIND_CHECKSUM = 2'd3
  } kind_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [2:0]                        pre_count;
    logic [NUM_PRE_REGS-1:0][7:0]      pre_byte;
  } cfg_t;

  // One classified command between front and back
  typedef struct packed {
    logic       is_hdr;
    logic [7:0] data;
    logic [7:0] sum;
    logic       with_sum;
  } cmd_t;

  // Push request from the front end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  // Rotate right by one, then add the byte modulo 256
  function automatic logic [7:0] sum_add(input logic [7:0] sum, input logic [7:0] b);
    logic [7:0] rot;
    rot = {sum[0], sum[7:1]};
    return (rot + b) & BYTE_MASK;
  endfunction

endpackage

>>> sv/fbrc_ifs.sv
// Input and result channel interfaces of the frame builder.
interface fbrc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] payload_length;
  logic [7:0] payload_byte;

  modport source (output valid, output mode, output payload_length, output payload_byte,
                  input ready);
  modport sink (input valid, input mode, input payload_length, input payload_byte,
                output ready);
endinterface

interface fbrc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;
  logic       frame_end;
  logic       run_last;

  modport source (output valid, output out_byte, output byte_kind, output frame_end,
                  output run_last, input ready);
  modport sink (input valid, input out_byte, input byte_kind, input frame_end,
                input run_last, output ready);
endinterface

>>> sv/fbrc_front.sv
// Front end: accepts input transactions, tracks the frame and the checksum.
module fbrc_front (
  input  logic               clk,
  input  logic               rst_n,
  fbrc_in_if.sink            in_chan,
  input  logic               q_full,
  output fbrc_pkg::push_t    push
);

  logic [7:0] sum_r, sum_nxt;
  logic [7:0] left_r, left_nxt;
  logic       open_r, open_nxt;
  logic       accept;
  logic [7:0] pay_sum;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign pay_sum       = fbrc_pkg::sum_add(sum_r, in_chan.payload_byte);

  // Classify the transaction and update the frame state
  always_comb begin
    sum_nxt  = sum_r;
    left_nxt = left_r;
    open_nxt = open_r;
    push     = '0;
    if (accept) begin
      if (in_chan.mode == fbrc_pkg::MODE_HEADER) begin
        // Rotating a zero sum leaves zero, so the sum is the length itself
        sum_nxt           = in_chan.payload_length;
        left_nxt          = in_chan.payload_length;
        open_nxt          = (in_chan.payload_length != 8'd0);
        push.valid        = 1'b1;
        push.cmd.is_hdr   = 1'b1;
        push.cmd.data     = in_chan.payload_length;
        push.cmd.sum      = in_chan.payload_length;
        push.cmd.with_sum = (in_chan.payload_length == 8'd0);
      end else if (open_r) begin
        sum_nxt           = pay_sum;
        left_nxt          = left_r - 8'd1;
        open_nxt          = (left_r != 8'd1);
        push.valid        = 1'b1;
        push.cmd.is_hdr   = 1'b0;
        push.cmd.data     = in_chan.payload_byte;
        push.cmd.sum      = pay_sum;
        push.cmd.with_sum = (left_r == 8'd1);
      end
      // Payload with no open frame: drop
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      left_r <= '0;
      open_r <= 1'b0;
    end else begin
      sum_r  <= sum_nxt;
      left_r <= left_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

>>> sv/fbrc_queue.sv
// Short command queue between the front end and the back end.
module fbrc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  fbrc_pkg::push_t    push,
  input  logic               pop,
  output fbrc_pkg::head_t    head,
  output logic               full
);

  localparam int Depth = fbrc_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  fbrc_pkg::cmd_t      slot_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign full       = (count_r == CntW'(Depth));
  assign head.valid = (count_r != '0);
  assign head.cmd   = slot_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the command payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.cmd;
    end
  end

endmodule

>>> sv/fbrc_back.sv
// Back end: expands each command into frame bytes, one per cycle while the output is not stalled.
module fbrc_back #(
  parameter int MAX_PREAMBLE = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fbrc_pkg::cfg_t     cfg,
  input  fbrc_pkg::head_t    head,
  output logic               pop,
  fbrc_out_if.source         out_chan
);

  localparam int PosW = $clog2(MAX_PREAMBLE + 2);

  logic [PosW-1:0]     pos_r, pos_nxt;
  logic [PosW-1:0]     sat_cnt, pre_cnt, last_pos;
  logic                advance, is_last;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          byte_r, byte_nxt;
  fbrc_pkg::kind_t     kind_r, kind_nxt;
  logic                end_r, end_nxt;
  logic                last_r;

  // Saturate the preamble count; payload commands carry no preamble
  assign sat_cnt  = (int'(cfg.pre_count) > MAX_PREAMBLE) ? PosW'(MAX_PREAMBLE)
                                                          : PosW'(cfg.pre_count);
  assign pre_cnt  = head.cmd.is_hdr ? sat_cnt : '0;
  assign last_pos = pre_cnt + PosW'(head.cmd.with_sum);
  assign is_last  = (pos_r == last_pos);
  assign advance  = head.valid && (!out_valid_r || out_chan.ready);
  assign pop      = advance && is_last;

  // Select the byte at the current position
  always_comb begin
    if (pos_r < pre_cnt) begin
      byte_nxt = (int'(pos_r) < fbrc_pkg::NUM_PRE_REGS) ? cfg.pre_byte[pos_r[1:0]] : 8'h00;
      kind_nxt = fbrc_pkg::KIND_PREAMBLE;
      end_nxt  = 1'b0;
    end else if (pos_r == pre_cnt) begin
      byte_nxt = head.cmd.data;
      kind_nxt = head.cmd.is_hdr ? fbrc_pkg::KIND_LENGTH : fbrc_pkg::KIND_PAYLOAD;
      end_nxt  = 1'b0;
    end else begin
      byte_nxt = head.cmd.sum;
      kind_nxt = fbrc_pkg::KIND_CHECKSUM;
      end_nxt  = 1'b1;
    end
  end

  // Step through the command, restart on the last byte
  always_comb begin
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      pos_nxt       = is_last ? '0 : pos_r + PosW'(1);
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the output payload until taken
  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r <= byte_nxt;
      kind_r <= kind_nxt;
      end_r  <= end_nxt;
      last_r <= is_last;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_byte  = byte_r;
  assign out_chan.byte_kind = kind_r;
  assign out_chan.frame_end = end_r;
  assign out_chan.run_last  = last_r;

endmodule

>>> sv/frame_builder_rotating_checksum_top.sv
// Path: an accepted transaction is registered in the queue, then in the back-end output register.
// Throughput: one output byte per cycle from the back-end output register while out_chan.ready
// is high; a payload transaction yields 1 byte (2 when it closes the frame), a header yields the saturated
// preamble count plus 1 (plus 1 more for a zero length). Input stalls only on a full queue.
// Reset: synchronous, active-low rst_n; clears frame state and queue, preamble count to 2,
// preamble bytes to zero.
`include "frame_builder_rotating_checksum_top_defines.svh"

module frame_builder_rotating_checksum_top #(
  parameter int MAX_PREAMBLE = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  fbrc_in_if.sink     in_chan,
  fbrc_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [7:0]  cfg_wdata
);

  fbrc_pkg::cfg_t   cfg_r;
  fbrc_pkg::push_t  push;
  fbrc_pkg::head_t  head;
  logic             q_full;
  logic             pop;

  // Configuration register writes; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pre_count <= fbrc_pkg::PRE_COUNT_RESET;
      cfg_r.pre_byte  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        fbrc_pkg::CFG_PRE_COUNT: cfg_r.pre_count   <= cfg_wdata[2:0];
        fbrc_pkg::CFG_PRE_BYTE0: cfg_r.pre_byte[0] <= cfg_wdata;
        fbrc_pkg::CFG_PRE_BYTE1: cfg_r.pre_byte[1] <= cfg_wdata;
        fbrc_pkg::CFG_PRE_BYTE2: cfg_r.pre_byte[2] <= cfg_wdata;
        fbrc_pkg::CFG_PRE_BYTE3: cfg_r.pre_byte[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fbrc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .push    (push)
  );

  fbrc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  fbrc_back #(
    .MAX_PREAMBLE (MAX_PREAMBLE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

  // A header transaction always leaves a command waiting in the queue
  `FBRC_ASSERT_NEXT(a_hdr_queued, in_chan.valid && in_chan.ready && (in_chan.mode == fbrc_pkg::MODE_HEADER), head.valid, "header transaction did not reach the queue")

  // The frame end byte is a checksum and closes its transaction
  `FBRC_ASSERT_NOW(a_end_is_last, out_chan.valid && out_chan.frame_end, out_chan.run_last && (out_chan.byte_kind == fbrc_pkg::KIND_CHECKSUM), "frame end not on last checksum byte")

  // A preamble byte is always followed by the length byte
  `FBRC_ASSERT_NOW(a_pre_not_last, out_chan.valid && (out_chan.byte_kind == fbrc_pkg::KIND_PREAMBLE), !out_chan.run_last && !out_chan.frame_end, "preamble byte marked as last")

endmodule

>>> verif/tb.sv
// Self-checking testbench for the frame builder with rotating 8-bit checksum.
module tb;

  localparam int PREAMBLE_CAP  = 4;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0]       data;
    fbrc_pkg::kind_t  kind;
    logic             frame_end;
    logic             run_last;
  } frame_byte_t;

  // Tracks frame state and the bytes the block must still send
  class frame_checker;
    logic [2:0]  pre_count;
    logic [7:0]  pre_byte [PREAMBLE_CAP];
    logic [7:0]  csum;
    logic [7:0]  bytes_left;
    bit          in_frame;
    frame_byte_t expected_bytes [$];
    int unsigned errors;

    function new();
      pre_count  = fbrc_pkg::PRE_COUNT_RESET;
      foreach (pre_byte[i]) pre_byte[i] = 8'h00;
      csum       = 8'h00;
      bytes_left = 8'h00;
      in_frame   = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] v);
      case (idx)
        fbrc_pkg::CFG_PRE_COUNT: pre_count   = v[2:0];
        fbrc_pkg::CFG_PRE_BYTE0: pre_byte[0] = v;
        fbrc_pkg::CFG_PRE_BYTE1: pre_byte[1] = v;
        fbrc_pkg::CFG_PRE_BYTE2: pre_byte[2] = v;
        fbrc_pkg::CFG_PRE_BYTE3: pre_byte[3] = v;
        default: ;
      endcase
    endfunction

    // Rotate right by one, then add the byte modulo 256
    function logic [7:0] rotate_add(logic [7:0] s, logic [7:0] b);
      return {s[0], s[7:1]} + b;
    endfunction

    function void push_byte(logic [7:0] d, fbrc_pkg::kind_t k, logic e);
      frame_byte_t rec;
      rec.data       = d;
      rec.kind       = k;
      rec.frame_end  = e;
      rec.run_last   = 1'b0;
      expected_bytes = {expected_bytes, rec};
    endfunction

    function void take_item(logic mode, logic [7:0] len, logic [7:0] b);
      int          first;
      int          n_pre;
      first = expected_bytes.size();
      if (mode == fbrc_pkg::MODE_HEADER) begin
        // saturate the preamble count, then open a fresh frame
        n_pre = (pre_count > PREAMBLE_CAP) ? PREAMBLE_CAP : int'(pre_count);
        for (int i = 0; i < n_pre; i++) push_byte(pre_byte[i], fbrc_pkg::KIND_PREAMBLE, 1'b0);
        csum = rotate_add(8'h00, len);
        push_byte(len, fbrc_pkg::KIND_LENGTH, 1'b0);
        bytes_left = len;
        in_frame   = (len != 8'h00);
        if (len == 8'h00) push_byte(csum, fbrc_pkg::KIND_CHECKSUM, 1'b1);
      end else if (in_frame) begin
        csum = rotate_add(csum, b);
        push_byte(b, fbrc_pkg::KIND_PAYLOAD, 1'b0);
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'h00) begin
          push_byte(csum, fbrc_pkg::KIND_CHECKSUM, 1'b1);
          in_frame = 1'b0;
        end
      end
      // flag the last byte this transaction produced
      if (expected_bytes.size() > first) begin
        expected_bytes[expected_bytes.size() - 1].run_last = 1'b1;
      end
    endfunction

    function void check_byte(frame_byte_t got);
      frame_byte_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte %02h kind %0d end %0b last %0b", $time,
                 got.data, got.kind, got.frame_end, got.run_last);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.data !== want.data || got.kind !== want.kind ||
          got.frame_end !== want.frame_end || got.run_last !== want.run_last) begin
        errors++;
        $display("%0t: byte mismatch: expected %02h/%0d/%0b/%0b got %02h/%0d/%0b/%0b",
                 $time, want.data, want.kind, want.frame_end, want.run_last,
                 got.data, got.kind, got.frame_end, got.run_last);
      end
    endfunction
  endclass

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [7:0]  cfg_wdata;
  int          src_idle_pct;
  int          sink_idle_pct;
  frame_checker chk;
  frame_byte_t  seen;

  fbrc_in_if  in_if ();
  fbrc_out_if out_if ();

  frame_builder_rotating_checksum_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99) >= sink_idle_pct);
  end

  // Note accepted inputs and check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        chk.take_item(in_if.mode, in_if.payload_length, in_if.payload_byte);
      if (out_if.valid && out_if.ready) begin
        seen.data      = out_if.out_byte;
        seen.kind      = fbrc_pkg::kind_t'(out_if.byte_kind);
        seen.frame_end = out_if.frame_end;
        seen.run_last  = out_if.run_last;
        chk.check_byte(seen);
      end
    end
  end

  // Write one register; call at a falling edge
  task automatic cfg_write(logic [2:0] idx, logic [7:0] v);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = v;
    chk.set_reg(idx, v);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_preamble(logic [2:0] cnt, logic [7:0] b0, logic [7:0] b1,
                              logic [7:0] b2, logic [7:0] b3);
    cfg_write(fbrc_pkg::CFG_PRE_COUNT, {5'd0, cnt});
    cfg_write(fbrc_pkg::CFG_PRE_BYTE0, b0);
    cfg_write(fbrc_pkg::CFG_PRE_BYTE1, b1);
    cfg_write(fbrc_pkg::CFG_PRE_BYTE2, b2);
    cfg_write(fbrc_pkg::CFG_PRE_BYTE3, b3);
  endtask

  // Offer one transaction after random idle cycles; returns at a falling edge
  task automatic send_item(logic mode, logic [7:0] len, logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid          = 1'b1;
    in_if.mode           = mode;
    in_if.payload_length = len;
    in_if.payload_byte   = b;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic send_header(logic [7:0] len);
    send_item(fbrc_pkg::MODE_HEADER, len, 8'($urandom_range(255)));
  endtask

  task automatic send_payload(logic [7:0] b);
    send_item(fbrc_pkg::MODE_PAYLOAD, 8'($urandom_range(255)), b);
  endtask

  // Hold the sender until every expected byte is out, then let the pipe settle
  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (chk.expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly complete frames, some cut short, a few stray payload bytes
  task automatic run_phase(int n_items);
    int sent;
    int r;
    int len;
    int cut;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 75) begin
        len = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
        send_header(8'(len));
        for (int i = 0; i < len; i++) send_payload(8'($urandom_range(255)));
        sent += len + 1;
      end else if (r < 92) begin
        len = $urandom_range(255);
        cut = $urandom_range(3);
        send_header(8'(len));
        for (int i = 0; i < cut; i++) send_payload(8'($urandom_range(255)));
        sent += cut + 1;
      end else begin
        send_payload(8'($urandom_range(255)));
        sent += 1;
      end
    end
  endtask

  initial begin
    chk                  = new();
    in_if.valid          = 1'b0;
    in_if.mode           = fbrc_pkg::MODE_HEADER;
    in_if.payload_length = 8'h00;
    in_if.payload_byte   = 8'h00;
    out_if.ready         = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = fbrc_pkg::CFG_PRE_COUNT;
    cfg_wdata            = 8'h00;
    src_idle_pct         = 8;
    sink_idle_pct        = 67;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset configuration: payload with no frame open is dropped
    send_payload(8'hFF);
    // zero length closes the frame in the header
    send_header(8'h00);
    send_header(8'h02);
    send_payload(8'h00);
    send_payload(8'hFF);
    // a new header abandons the open frame
    send_header(8'hFF);
    send_payload(8'hA5);
    send_header(8'h01);
    send_payload(8'h80);
    send_payload(8'h5A);
    wait_drained();

    // No preamble at all
    set_preamble(3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_header(8'h01);
    send_payload(8'h7E);
    send_header(8'h80);
    send_payload(8'h01);
    wait_drained();

    // Count above the cap saturates
    set_preamble(3'd7, 8'hFF, 8'h00, 8'hAA, 8'h55);
    send_header(8'h00);
    send_header(8'h01);
    send_payload(8'hFF);
    wait_drained();

    set_preamble(3'd4, 8'h00, 8'hFF, 8'h55, 8'hAA);
    send_header(8'h00);
    wait_drained();

    // Random traffic, sender mostly busy, receiver stalling often
    set_preamble(3'd1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
    run_phase(62);
    wait_drained();

    // Sender idling often, receiver mostly ready
    src_idle_pct  = 67;
    sink_idle_pct = 8;
    set_preamble(3'd4, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
    run_phase(62);
    wait_drained();

    // Back to back, no idling on either side
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_preamble(3'($urandom_range(7)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
    run_phase(62);
    wait_drained();

    if (chk.errors == 0 && chk.expected_bytes.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #3000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
